// File: rtl/core/owm_pkg.sv
// ----------------------------------------------------------------------------
// owm_pkg: shared types and constants of the 1-Wire bus master
// Holds the item structs of both channels, the command codes, the
// configuration register indexes and their reset values.
// ----------------------------------------------------------------------------
package owm_pkg;

    // Command codes carried by an input item.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_RESET = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_RESET_RELEASE = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SHORT_PULSE   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_LONG_PULSE    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SAMPLE_DELAY  = 3'd4;

    // Every duration register is ten bits wide.
    localparam int unsigned CFG_BITS = 10;

    // Reset values of the duration registers.
    localparam logic [CFG_BITS-1:0] RST_RESET_LOW     = 10'd600;
    localparam logic [CFG_BITS-1:0] RST_RESET_RELEASE = 10'd700;
    localparam logic [CFG_BITS-1:0] RST_SHORT_PULSE   = 10'd2;
    localparam logic [CFG_BITS-1:0] RST_LONG_PULSE    = 10'd80;
    localparam logic [CFG_BITS-1:0] RST_SAMPLE_DELAY  = 10'd6;

    // Duration registers as one group.
    typedef struct packed {
        logic [CFG_BITS-1:0] reset_low_time;
        logic [CFG_BITS-1:0] reset_release_time;
        logic [CFG_BITS-1:0] short_pulse_time;
        logic [CFG_BITS-1:0] long_pulse_time;
        logic [CFG_BITS-1:0] read_sample_delay;
    } t_cfg;

    // One input item: one microsecond tick.
    typedef struct packed {
        logic [1:0] command;
        logic [7:0] tx_byte;
        logic       line_level;
    } t_in_item;

    // One result item: bus drive and status for that tick.
    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       presence;
    } t_out_item;

endpackage

// File: rtl/core/one_wire_master.sv
// ----------------------------------------------------------------------------
// one_wire_master: bit-timing engine of a 1-Wire bus master
// The result of a tick item is written to the output register at the edge
// that accepts the item. Throughput: one tick item per clock cycle while the
// result side does not stall, as the phase timer and slot state update at once.
// Reset (synchronous, active low) returns the engine to idle, clears the
// output valid flag, presence and received byte, and loads default timings.
// ----------------------------------------------------------------------------
module one_wire_master #(
    parameter int TIMER_BITS = 10
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Tick channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  owm_pkg::t_in_item                    i_in_data,
    // Result channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output owm_pkg::t_out_item                   o_out_data,
    // Configuration write port
    input  logic                                 i_cfg_we,
    input  logic [owm_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [owm_pkg::CFG_BITS-1:0]         i_cfg_data
);

    localparam int unsigned TIMER_MAX = (2 ** TIMER_BITS) - 1;

    typedef enum logic [1:0] {
        OP_IDLE  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    // Slot phases: driven low, released (sample window), recovery.
    localparam logic [1:0] PH_LOW     = 2'd0;
    localparam logic [1:0] PH_RELEASE = 2'd1;
    localparam logic [1:0] PH_RECOVER = 2'd2;

    owm_pkg::t_cfg          r_cfg;
    t_op                    r_op,      n_op;
    logic [1:0]             r_phase,   n_phase;
    logic [2:0]             r_bit,     n_bit;
    logic [7:0]             r_shift,   n_shift;
    logic [TIMER_BITS-1:0]  r_timer,   n_timer;
    logic                   r_presence, n_presence;
    logic [7:0]             r_rx,      n_rx;
    logic                   r_out_valid;
    owm_pkg::t_out_item     r_out,     n_out;
    logic                   in_accept;

    // Length of the current phase, minus one, clamped to the timer range.
    function automatic logic [TIMER_BITS-1:0] phase_load(
        input owm_pkg::t_cfg cfg,
        input t_op           op,
        input logic [1:0]    phase,
        input logic          bitval
    );
        logic [owm_pkg::CFG_BITS-1:0] len;
        logic [owm_pkg::CFG_BITS-1:0] len_m1;
        begin
            if (op == OP_RESET) begin
                len = (phase == PH_LOW) ? cfg.reset_low_time : cfg.reset_release_time;
            end else if (op == OP_WRITE) begin
                if (phase == PH_LOW) begin
                    len = bitval ? cfg.short_pulse_time : cfg.long_pulse_time;
                end else begin
                    len = bitval ? cfg.long_pulse_time : cfg.short_pulse_time;
                end
            end else if (phase == PH_LOW) begin
                len = cfg.short_pulse_time;
            end else if (phase == PH_RELEASE) begin
                len = cfg.read_sample_delay;
            end else begin
                len = cfg.long_pulse_time;
            end
            // A zero duration counts as one tick.
            len_m1 = (len == '0) ? '0 : len - 1'b1;
            if (32'(len_m1) > 32'(TIMER_MAX)) begin
                phase_load = '1;
            end else begin
                phase_load = TIMER_BITS'(len_m1);
            end
        end
    endfunction

    // The tick is taken whenever the output register is free or being drained.
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Next state and result for one tick.
    always_comb begin
        logic drive;
        logic busy;
        logic done;
        drive      = 1'b0;
        busy       = 1'b0;
        done       = 1'b0;
        n_op       = r_op;
        n_phase    = r_phase;
        n_bit      = r_bit;
        n_shift    = r_shift;
        n_timer    = r_timer;
        n_presence = r_presence;
        n_rx       = r_rx;

        // An idle engine starts a command; this tick is its first.
        if (r_op == OP_IDLE && i_in_data.command != owm_pkg::CMD_TICK) begin
            n_op    = t_op'(i_in_data.command);
            n_bit   = '0;
            n_shift = (i_in_data.command == owm_pkg::CMD_WRITE) ? i_in_data.tx_byte : '0;
            n_phase = PH_LOW;
            n_timer = phase_load(r_cfg, n_op, PH_LOW, n_shift[0]);
        end

        if (n_op != OP_IDLE) begin
            busy  = 1'b1;
            drive = (n_phase == PH_LOW);
            if (n_timer != '0) begin
                n_timer = n_timer - 1'b1;
            end else if (n_phase == PH_LOW) begin
                n_phase = PH_RELEASE;
                n_timer = phase_load(r_cfg, n_op, PH_RELEASE, n_shift[n_bit]);
            end else if (n_op == OP_RESET) begin
                // Presence: a device holds the line low at the end of the window.
                n_presence = !i_in_data.line_level;
                n_op       = OP_IDLE;
                n_phase    = PH_LOW;
                done       = 1'b1;
            end else if (n_op == OP_READ && n_phase == PH_RELEASE) begin
                n_shift[n_bit] = n_shift[n_bit] | i_in_data.line_level;
                n_phase        = PH_RECOVER;
                n_timer        = phase_load(r_cfg, n_op, PH_RECOVER, n_shift[n_bit]);
            end else begin
                // End of a write slot or of a read recovery.
                if (n_op == OP_READ && n_bit == 3'd7) begin
                    n_rx = n_shift;
                end
                if (n_bit == 3'd7) begin
                    n_op    = OP_IDLE;
                    n_phase = PH_LOW;
                    n_bit   = '0;
                    done    = 1'b1;
                end else begin
                    n_bit   = n_bit + 1'b1;
                    n_phase = PH_LOW;
                    n_timer = phase_load(r_cfg, n_op, PH_LOW, n_shift[n_bit]);
                end
            end
        end

        n_out.drive_low = drive;
        n_out.busy_res  = busy;
        n_out.done_res  = done;
        n_out.rx_byte   = n_rx;
        n_out.presence  = n_presence;
    end

    // State, configuration and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_time     <= owm_pkg::RST_RESET_LOW;
            r_cfg.reset_release_time <= owm_pkg::RST_RESET_RELEASE;
            r_cfg.short_pulse_time   <= owm_pkg::RST_SHORT_PULSE;
            r_cfg.long_pulse_time    <= owm_pkg::RST_LONG_PULSE;
            r_cfg.read_sample_delay  <= owm_pkg::RST_SAMPLE_DELAY;
            r_op        <= OP_IDLE;
            r_phase     <= PH_LOW;
            r_bit       <= '0;
            r_shift     <= '0;
            r_timer     <= '0;
            r_presence  <= 1'b0;
            r_rx        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    owm_pkg::REG_RESET_LOW:     r_cfg.reset_low_time     <= i_cfg_data;
                    owm_pkg::REG_RESET_RELEASE: r_cfg.reset_release_time <= i_cfg_data;
                    owm_pkg::REG_SHORT_PULSE:   r_cfg.short_pulse_time   <= i_cfg_data;
                    owm_pkg::REG_LONG_PULSE:    r_cfg.long_pulse_time    <= i_cfg_data;
                    owm_pkg::REG_SAMPLE_DELAY:  r_cfg.read_sample_delay  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_accept) begin
                r_op        <= n_op;
                r_phase     <= n_phase;
                r_bit       <= n_bit;
                r_shift     <= n_shift;
                r_timer     <= n_timer;
                r_presence  <= n_presence;
                r_rx        <= n_rx;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

endmodule

// File: rtl/core/owm_checker.sv
// ----------------------------------------------------------------------------
// owm_checker: port-level checks of the 1-Wire bus master
// Watches the channels of the top level and flags results that break the
// bus rules or the flow of items.
// ----------------------------------------------------------------------------
module owm_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_in_ready,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input owm_pkg::t_out_item               o_out_data
);

    // The bus is pulled low only while an operation runs.
    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.drive_low |-> o_out_data.busy_res)
        else $error("bus driven low outside an operation");

    // A completing tick is part of its operation.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.done_res |-> o_out_data.busy_res)
        else $error("done reported while not busy");

    // An empty output register never holds back a tick.
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("tick refused with an empty output register");

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result dropped or changed");

endmodule

bind one_wire_master owm_checker u_owm_checker (.*);

// File: test/one_wire_master_chk.sv
// ----------------------------------------------------------------------------
// one_wire_master_chk: result checker for the 1-Wire bus master
// Follows the timing registers and every accepted tick item. It keeps its
// own model of the slot engine and compares each accepted result field by
// field with the oldest status it has worked out. It reports the number of
// failures, the number of results still owed and whether an operation runs.
// ----------------------------------------------------------------------------
module one_wire_master_chk (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  owm_pkg::t_in_item                i_in_data,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  owm_pkg::t_out_item               i_out_data,
    input  logic                             i_cfg_we,
    input  logic [owm_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [owm_pkg::CFG_BITS-1:0]     i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending,
    output logic                             o_engine_busy
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [owm_pkg::CFG_BITS-1:0] t_dur;

    // Slot phases: bus held low, released, then recovery (read slots only).
    localparam logic [1:0] PH_LOW     = 2'd0;
    localparam logic [1:0] PH_RELEASE = 2'd1;
    localparam logic [1:0] PH_RECOVER = 2'd2;

    // An idle engine carries the tick-only code as its operation.
    localparam logic [1:0] OP_IDLE = owm_pkg::CMD_TICK;

    owm_pkg::t_cfg       timing;
    logic [1:0]          op;
    logic [1:0]          phase;
    logic [2:0]          bit_idx;
    logic [7:0]          shreg;
    t_dur                timer;
    logic                pres;
    logic [7:0]          rx_hold;
    owm_pkg::t_out_item  bus_status_q[$];

    // Timer load for a phase: its length minus one, a zero length counting as one.
    function automatic t_dur phase_ticks(input logic [1:0] ph);
        t_dur len;
        logic cur;
        cur = shreg[bit_idx];
        case (op)
            owm_pkg::CMD_RESET: begin
                len = (ph == PH_LOW) ? timing.reset_low_time : timing.reset_release_time;
            end
            owm_pkg::CMD_WRITE: begin
                if (ph == PH_LOW) begin
                    len = cur ? timing.short_pulse_time : timing.long_pulse_time;
                end else begin
                    len = cur ? timing.long_pulse_time : timing.short_pulse_time;
                end
            end
            default: begin
                if (ph == PH_LOW) begin
                    len = timing.short_pulse_time;
                end else if (ph == PH_RELEASE) begin
                    len = timing.read_sample_delay;
                end else begin
                    len = timing.long_pulse_time;
                end
            end
        endcase
        if (len == '0) begin
            len = t_dur'(1);
        end
        return len - 1'b1;
    endfunction

    function automatic void enter_phase(input logic [1:0] ph);
        phase = ph;
        timer = phase_ticks(ph);
    endfunction

    // End of a bit slot: move to the next bit, or finish after the eighth.
    function automatic logic finish_slot();
        if (bit_idx == 3'd7) begin
            op      = OP_IDLE;
            phase   = PH_LOW;
            bit_idx = '0;
            return 1'b1;
        end
        bit_idx = bit_idx + 1'b1;
        enter_phase(PH_LOW);
        return 1'b0;
    endfunction

    // Advance the engine by one tick and return the bus status of that tick.
    function automatic owm_pkg::t_out_item engine_tick(input owm_pkg::t_in_item tick);
        owm_pkg::t_out_item st;
        st = '0;
        if (op == OP_IDLE && tick.command != owm_pkg::CMD_TICK) begin
            op      = tick.command;
            bit_idx = '0;
            shreg   = (tick.command == owm_pkg::CMD_WRITE) ? tick.tx_byte : 8'h00;
            enter_phase(PH_LOW);
        end
        if (op != OP_IDLE) begin
            st.busy_res  = 1'b1;
            st.drive_low = (phase == PH_LOW);
            if (timer != '0) begin
                timer = timer - 1'b1;
            end else if (phase == PH_LOW) begin
                enter_phase(PH_RELEASE);
            end else if (op == owm_pkg::CMD_RESET) begin
                // Presence is a low line on the last release tick.
                pres        = !tick.line_level;
                op          = OP_IDLE;
                phase       = PH_LOW;
                st.done_res = 1'b1;
            end else if (op == owm_pkg::CMD_WRITE) begin
                st.done_res = finish_slot();
            end else if (phase == PH_RELEASE) begin
                shreg[bit_idx] = shreg[bit_idx] | tick.line_level;
                enter_phase(PH_RECOVER);
            end else begin
                if (bit_idx == 3'd7) begin
                    rx_hold = shreg;
                end
                st.done_res = finish_slot();
            end
        end
        st.rx_byte  = rx_hold;
        st.presence = pres;
        return st;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            o_fail_count++;
        end
    endfunction

    // Results are taken before ticks, since a result always belongs to an
    // earlier tick than one accepted at the same edge.
    always @(posedge i_clk) begin
        owm_pkg::t_out_item want;
        owm_pkg::t_out_item got;
        if (!i_rst_n) begin
            timing.reset_low_time     = owm_pkg::RST_RESET_LOW;
            timing.reset_release_time = owm_pkg::RST_RESET_RELEASE;
            timing.short_pulse_time   = owm_pkg::RST_SHORT_PULSE;
            timing.long_pulse_time    = owm_pkg::RST_LONG_PULSE;
            timing.read_sample_delay  = owm_pkg::RST_SAMPLE_DELAY;
            op           = OP_IDLE;
            phase        = PH_LOW;
            bit_idx      = '0;
            shreg        = '0;
            timer        = '0;
            pres         = 1'b0;
            rx_hold      = '0;
            o_fail_count = 0;
            bus_status_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (bus_status_q.size() == 0) begin
                    $error("result item arrived with no tick outstanding");
                    o_fail_count++;
                end else begin
                    want = bus_status_q.pop_front();
                    check_field("drive_low", 8'(want.drive_low), 8'(got.drive_low));
                    check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
                    check_field("done_res", 8'(want.done_res), 8'(got.done_res));
                    check_field("rx_byte", want.rx_byte, got.rx_byte);
                    check_field("presence", 8'(want.presence), 8'(got.presence));
                end
            end
            if (i_in_valid && i_in_ready) begin
                bus_status_q.push_back(engine_tick(i_in_data));
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    owm_pkg::REG_RESET_LOW:     timing.reset_low_time     = i_cfg_data;
                    owm_pkg::REG_RESET_RELEASE: timing.reset_release_time = i_cfg_data;
                    owm_pkg::REG_SHORT_PULSE:   timing.short_pulse_time   = i_cfg_data;
                    owm_pkg::REG_LONG_PULSE:    timing.long_pulse_time    = i_cfg_data;
                    owm_pkg::REG_SAMPLE_DELAY:  timing.read_sample_delay  = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending     = bus_status_q.size();
        o_engine_busy = (op != OP_IDLE);
    end

endmodule

// File: test/one_wire_master_tb.sv
// ----------------------------------------------------------------------------
// one_wire_master_tb: testbench top of the 1-Wire bus master
// Drives tick items and timing register writes, stalls the result side,
// and gives the verdict from the checker's failure count. Runs a read at
// the default timings, bus resets, writes and reads at zero durations, and
// then random tick streams under random timing sets.
// ----------------------------------------------------------------------------
module one_wire_master_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [owm_pkg::CFG_BITS-1:0] t_dur;

    // Cycles without any transfer before the run is declared hung.
    localparam int QUIET_LIMIT = 5000;
    // Long receiver hold-off and the point at which it starts.
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AT     = 400;
    // Stretch in which neither side idles.
    localparam int BUSY_FROM   = 100;
    localparam int BUSY_TO     = 350;
    // Rough number of tick items for the whole run.
    localparam int ITEM_TARGET   = 1150;
    localparam int TICKS_PER_SET = 60;

    typedef enum logic [1:0] {LINE_LOW, LINE_HIGH, LINE_RANDOM} t_line_mode;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             in_valid  = 1'b0;
    logic                             in_ready;
    owm_pkg::t_in_item                in_data   = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    owm_pkg::t_out_item               out_data;
    logic                             cfg_we    = 1'b0;
    logic [owm_pkg::CFG_IDX_BITS-1:0] cfg_index = owm_pkg::REG_RESET_LOW;
    t_dur                             cfg_data  = '0;

    int   fail_count;
    int   pending;
    logic engine_busy;
    int   sent_items   = 0;
    int   results_seen = 0;
    int   quiet_cycles = 0;
    int   hold_left    = 0;
    logic hold_done    = 1'b0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    one_wire_master dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    one_wire_master_chk chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_engine_busy (engine_busy)
    );

    // Result side: random stalls, one long hold-off while ticks keep coming,
    // and a stretch without stalls.
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (results_seen >= BUSY_FROM && results_seen < BUSY_TO) begin
            out_ready <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(99) >= 34);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            results_seen <= results_seen + 1;
        end
    end

    // Watchdog on cycles in which nothing moves.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("one_wire_master verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one tick item and return at the falling edge after it is taken.
    task automatic send_item(input owm_pkg::t_in_item tick);
        if (sent_items < BUSY_FROM || sent_items >= BUSY_TO) begin
            while ($urandom_range(99) < 34) begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= tick;
        do @(posedge clk); while (!in_ready);
        sent_items++;
        @(negedge clk);
    endtask

    function automatic logic line_for(input t_line_mode mode);
        case (mode)
            LINE_LOW:  return 1'b0;
            LINE_HIGH: return 1'b1;
            default:   return 1'($urandom_range(1));
        endcase
    endfunction

    // Tick fed while the engine is busy: its command must be ignored.
    function automatic owm_pkg::t_in_item busy_tick(input t_line_mode mode);
        owm_pkg::t_in_item tick;
        tick.command    = 2'($urandom_range(3));
        tick.tx_byte    = 8'($urandom);
        tick.line_level = line_for(mode);
        return tick;
    endfunction

    function automatic owm_pkg::t_in_item random_tick();
        owm_pkg::t_in_item tick;
        tick.command    = ($urandom_range(99) < 80) ? owm_pkg::CMD_TICK
                                                    : 2'($urandom_range(3, 1));
        tick.tx_byte    = 8'($urandom);
        tick.line_level = 1'($urandom_range(1));
        return tick;
    endfunction

    // Start one operation and tick it through to its end.
    task automatic run_op(input logic [1:0] cmd, input logic [7:0] tx,
                          input t_line_mode mode);
        send_item('{command: cmd, tx_byte: tx, line_level: line_for(mode)});
        while (engine_busy) begin
            send_item(busy_tick(mode));
        end
    endtask

    // Finish any running operation, then wait until every result is back.
    task automatic settle();
        while (engine_busy) begin
            send_item(busy_tick(LINE_RANDOM));
        end
        in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input logic [owm_pkg::CFG_IDX_BITS-1:0] idx,
                             input t_dur value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    task automatic program_timing(input owm_pkg::t_cfg t);
        write_reg(owm_pkg::REG_RESET_LOW, t.reset_low_time);
        write_reg(owm_pkg::REG_RESET_RELEASE, t.reset_release_time);
        write_reg(owm_pkg::REG_SHORT_PULSE, t.short_pulse_time);
        write_reg(owm_pkg::REG_LONG_PULSE, t.long_pulse_time);
        write_reg(owm_pkg::REG_SAMPLE_DELAY, t.read_sample_delay);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly very short durations, now and then a longer one.
    function automatic t_dur random_duration();
        if ($urandom_range(9) == 0) begin
            return t_dur'($urandom_range(12, 1));
        end
        return t_dur'($urandom_range(3));
    endfunction

    function automatic owm_pkg::t_cfg random_timing();
        owm_pkg::t_cfg t;
        t.reset_low_time     = random_duration();
        t.reset_release_time = random_duration();
        t.short_pulse_time   = random_duration();
        t.long_pulse_time    = random_duration();
        t.read_sample_delay  = random_duration();
        return t;
    endfunction

    initial begin
        int n;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Default timings from reset: a read covers every slot duration.
        run_op(owm_pkg::CMD_READ, 8'h00, LINE_RANDOM);
        settle();

        // Zero durations behave as single ticks.
        program_timing('0);
        send_item('{command: owm_pkg::CMD_TICK, tx_byte: 8'hFF, line_level: 1'b1});
        run_op(owm_pkg::CMD_RESET, 8'h00, LINE_HIGH);
        run_op(owm_pkg::CMD_RESET, 8'hFF, LINE_LOW);
        run_op(owm_pkg::CMD_WRITE, 8'h00, LINE_RANDOM);
        run_op(owm_pkg::CMD_WRITE, 8'hFF, LINE_RANDOM);
        run_op(owm_pkg::CMD_READ, 8'h00, LINE_HIGH);
        run_op(owm_pkg::CMD_READ, 8'hFF, LINE_LOW);
        settle();

        // Random tick streams under random timing sets.
        while (sent_items < ITEM_TARGET - TICKS_PER_SET) begin
            program_timing(random_timing());
            for (n = 0; n < TICKS_PER_SET; n++) begin
                send_item(random_tick());
            end
            settle();
        end

        if (fail_count == 0) begin
            $display("one_wire_master verification clean");
        end else begin
            $display("one_wire_master verification failed");
        end
        $finish;
    end

endmodule
